// File: hdl/suptn_pkg.sv
// Package: shared constants, types and tables for the sound unit.
package suptn_pkg;

  localparam int unsigned PulseCountDef = 2;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 8;
  localparam int unsigned CfgW = 24;
  localparam int unsigned AccW = 25;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    FM_IDLE = 2'd0,
    FM_FOUR = 2'd1,
    FM_FIVE = 2'd2,
    FM_RSVD = 2'd3
  } frame_mode_e;

  localparam logic [0:0] CFG_FRAME  = 1'b0;
  localparam logic [0:0] CFG_SAMPLE = 1'b1;

  localparam logic [4:0] ADDR_TRI_LIN   = 5'h08;
  localparam logic [4:0] ADDR_TRI_LO    = 5'h0A;
  localparam logic [4:0] ADDR_TRI_HI    = 5'h0B;
  localparam logic [4:0] ADDR_NOISE_ENV = 5'h0C;
  localparam logic [4:0] ADDR_NOISE_PER = 5'h0E;
  localparam logic [4:0] ADDR_NOISE_LEN = 5'h0F;
  localparam logic [4:0] ADDR_STATUS    = 5'h15;
  localparam logic [4:0] ADDR_FRAME     = 5'h17;

  localparam logic [23:0] FrameResetQ8  = 24'd1909090;
  localparam logic [23:0] SampleResetQ8 = 24'd10389;
  localparam logic [24:0] Q8One         = 25'd256;

  typedef struct packed {
    logic       sample_valid;
    logic [4:0] pulse_mix;
    logic [6:0] tri_noise_mix;
    logic [7:0] read_data;
    logic       irq_pulse;
  } result_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] reg_address;
    logic [7:0] write_data;
  } item_t;

  // Frame sequencer strobes for the channel datapath.
  typedef struct packed {
    logic quarter;
    logic half;
  } frame_ev_t;

  function automatic logic [7:0] len_lookup(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;   5'd3: r = 8'd2;
      5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;   5'd7: r = 8'd6;
      5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60;  5'd11: r = 8'd10;
      5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
      5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
      5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
      5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
      5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] noise_lookup(input logic [3:0] idx);
    logic [11:0] r;
    case (idx)
      4'd0: r = 12'd4;     4'd1: r = 12'd8;     4'd2: r = 12'd16;    4'd3: r = 12'd32;
      4'd4: r = 12'd64;    4'd5: r = 12'd96;    4'd6: r = 12'd128;   4'd7: r = 12'd160;
      4'd8: r = 12'd202;   4'd9: r = 12'd254;   4'd10: r = 12'd380;  4'd11: r = 12'd508;
      4'd12: r = 12'd762;  4'd13: r = 12'd1016; 4'd14: r = 12'd2034; default: r = 12'd4068;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] duty_lookup(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h02;
      2'd1: r = 8'h06;
      2'd2: r = 8'h1E;
      default: r = 8'hF9;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/suptn_if.sv
// Interfaces: valid/ready item, result and configuration channels.
interface suptn_item_if;
  logic                 valid;
  logic                 ready;
  suptn_pkg::item_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface suptn_result_if;
  logic                 valid;
  logic                 ready;
  suptn_pkg::result_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface suptn_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/sound_unit_pulse_triangle_noise.sv
// Top level: sound unit with two pulse, triangle and noise channels.
// Usage:
//   in_if   : one transaction per CPU-cycle tick, register write or status read.
//   out_if  : exactly one result transaction per input transaction, in order.
//   cfg_if  : writes the frame step period (index 0) and sample period (index 1),
//             both 16.8 fixed point; write only while the block is idle.
// An accepted transaction updates the channel state and its result is held in
// the output register on the next cycle. Throughput is one transaction per
// cycle, set by the single output register: in_if.ready is high whenever the
// output register is empty or being drained in the same cycle. If the receiver
// stalls, the result holds and input is held off until it is taken. Reset
// clears all channel state (noise LFSR to one), leaves the frame sequencer idle
// and restores the default periods.
module sound_unit_pulse_triangle_noise #(
  parameter int unsigned PulseCount = suptn_pkg::PulseCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  suptn_item_if.sink       in_if,
  suptn_result_if.source   out_if,
  suptn_cfg_if.sink        cfg_if
);
  logic [23:0]          frame_per_q, sample_per_q;
  logic                 acc, tick, wr, rd;
  suptn_pkg::frame_ev_t ev;
  logic                 irq, due;
  logic [4:0]           pmix;
  logic [6:0]           tnmix;
  logic [7:0]           status;
  suptn_pkg::result_t   res_d, res_q;
  logic                 vld_q;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_per_q <= suptn_pkg::FrameResetQ8;
      sample_per_q <= suptn_pkg::SampleResetQ8;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == suptn_pkg::CFG_FRAME) frame_per_q <= cfg_if.data;
      else sample_per_q <= cfg_if.data;
    end
  end

  assign in_if.ready = !vld_q || out_if.ready;
  assign acc  = in_if.valid && in_if.ready;
  assign tick = acc && in_if.payload.opcode == suptn_pkg::OP_TICK;
  assign wr   = acc && in_if.payload.opcode == suptn_pkg::OP_WRITE;
  assign rd   = in_if.payload.opcode == suptn_pkg::OP_READ;

  suptn_timebase u_tb (
    .clk_i, .rst_ni, .tick_i(tick),
    .frame_wr_i(wr && in_if.payload.reg_address == suptn_pkg::ADDR_FRAME),
    .frame_data_i(in_if.payload.write_data),
    .frame_per_i(frame_per_q), .sample_per_i(sample_per_q),
    .ev_o(ev), .irq_o(irq), .sample_due_o(due)
  );

  suptn_channels #(.PulseCount(PulseCount)) u_ch (
    .clk_i, .rst_ni, .tick_i(tick), .wr_i(wr),
    .addr_i(in_if.payload.reg_address), .data_i(in_if.payload.write_data),
    .ev_i(ev), .pulse_mix_o(pmix), .tri_noise_mix_o(tnmix), .status_o(status)
  );

  // Mix reflects the channel state after this tick's timer and frame updates.
  always_comb begin
    res_d = '0;
    res_d.sample_valid = due;
    res_d.irq_pulse = irq;
    if (due) begin
      res_d.pulse_mix = pmix;
      res_d.tri_noise_mix = tnmix;
    end
    if (rd && in_if.payload.reg_address == suptn_pkg::ADDR_STATUS)
      res_d.read_data = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (in_if.ready) vld_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    if (acc) res_q <= res_d;
  end

  assign out_if.valid = vld_q;
  assign out_if.payload = res_q;
endmodule

// File: hdl/suptn_timebase.sv
// Frame and sample phase accumulators and the frame sequencer.
module suptn_timebase (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic                   frame_wr_i,
  input  logic [7:0]             frame_data_i,
  input  logic [23:0]            frame_per_i,
  input  logic [23:0]            sample_per_i,
  output suptn_pkg::frame_ev_t   ev_o,
  output logic                   irq_o,
  output logic                   sample_due_o
);
  logic [24:0] frame_acc_q, frame_acc_d, sample_acc_q, sample_acc_d;
  logic [24:0] fper, sper, fsum, ssum;
  logic [1:0]  mode_q, mode_d;
  logic [2:0]  step_q, step_d;
  logic        irq_en_q, irq_en_d;
  logic        fstep;

  always_comb begin
    fper = (frame_per_i < 24'd256) ? suptn_pkg::Q8One : {1'b0, frame_per_i};
    sper = (sample_per_i < 24'd256) ? suptn_pkg::Q8One : {1'b0, sample_per_i};
    fsum = frame_acc_q + suptn_pkg::Q8One;
    ssum = sample_acc_q + suptn_pkg::Q8One;
    frame_acc_d = frame_acc_q;
    sample_acc_d = sample_acc_q;
    mode_d = mode_q;
    step_d = step_q;
    irq_en_d = irq_en_q;
    ev_o = '0;
    irq_o = 1'b0;
    sample_due_o = 1'b0;
    fstep = 1'b0;
    if (tick_i) begin
      frame_acc_d = fsum;
      if (fsum >= fper) begin
        frame_acc_d = fsum - fper;
        fstep = 1'b1;
      end
      sample_acc_d = ssum;
      if (ssum >= sper) begin
        sample_acc_d = ssum - sper;
        sample_due_o = 1'b1;
      end
    end
    if (fstep) begin
      if (mode_q == suptn_pkg::FM_FOUR) begin
        // step 4 left over from the five-step mode wraps to 1
        step_d = (step_q >= 3'd3) ? step_q - 3'd3 : step_q + 3'd1;
        ev_o.quarter = 1'b1;
        ev_o.half = (step_d == 3'd1) || (step_d == 3'd3);
        irq_o = (step_d == 3'd3) && irq_en_q;
      end else if (mode_q == suptn_pkg::FM_FIVE) begin
        step_d = (step_q >= 3'd4) ? 3'd0 : step_q + 3'd1;
        ev_o.quarter = step_d <= 3'd3;
        ev_o.half = (step_d == 3'd1) || (step_d == 3'd3);
      end
    end
    if (frame_wr_i) begin
      mode_d = frame_data_i[7] ? suptn_pkg::FM_FIVE : suptn_pkg::FM_FOUR;
      irq_en_d = !frame_data_i[6];
      if (frame_data_i[7]) begin
        ev_o.quarter = 1'b1;
        ev_o.half = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_acc_q <= '0;
      sample_acc_q <= '0;
      mode_q <= suptn_pkg::FM_IDLE;
      step_q <= '0;
      irq_en_q <= 1'b0;
    end else begin
      frame_acc_q <= frame_acc_d;
      sample_acc_q <= sample_acc_d;
      mode_q <= mode_d;
      step_q <= step_d;
      irq_en_q <= irq_en_d;
    end
  end
endmodule

// File: hdl/suptn_channels.sv
// Pulse, triangle and noise channel state with register writes and levels.
module suptn_channels #(
  parameter int unsigned PulseCount = suptn_pkg::PulseCountDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic                 wr_i,
  input  logic [4:0]           addr_i,
  input  logic [7:0]           data_i,
  input  suptn_pkg::frame_ev_t ev_i,
  output logic [4:0]           pulse_mix_o,
  output logic [6:0]           tri_noise_mix_o,
  output logic [7:0]           status_o
);
  logic        par_q, par_d;
  logic [3:0]  en_q, en_d;
  logic [15:0] pper_q [2], pper_d [2], ptim_q [2], ptim_d [2];
  logic [1:0]  duty_q [2], duty_d [2];
  logic [2:0]  dstep_q [2], dstep_d [2];
  logic [7:0]  swc_q [2], swc_d [2];
  logic        swr_q [2], swr_d [2];
  logic [3:0]  swdiv_q [2], swdiv_d [2];
  logic [7:0]  len_q [4], len_d [4];
  logic        halt_q [4], halt_d [4];
  logic        est_q [3], est_d [3], econ_q [3], econ_d [3];
  logic [3:0]  eper_q [3], eper_d [3], ediv_q [3], ediv_d [3], evol_q [3], evol_d [3];
  logic [10:0] tper_q, tper_d, ttim_q, ttim_d;
  logic [4:0]  tstep_q, tstep_d;
  logic [6:0]  tlp_q, tlp_d, tlc_q, tlc_d;
  logic        tlr_q, tlr_d;
  logic [11:0] nper_q, nper_d, ntim_q, ntim_d;
  logic        nmode_q, nmode_d;
  logic [14:0] lfsr_q, lfsr_d;

  logic [3:0]  plev [2];
  logic [3:0]  tlev, nlev;
  logic [15:0] delta, tp;
  logic        fb, env_loop;
  logic [4:0]  pm;
  logic [7:0]  dmask;

  always_comb begin
    par_d = par_q; en_d = en_q;
    pper_d = pper_q; ptim_d = ptim_q; duty_d = duty_q; dstep_d = dstep_q;
    swc_d = swc_q; swr_d = swr_q; swdiv_d = swdiv_q;
    len_d = len_q; halt_d = halt_q;
    est_d = est_q; econ_d = econ_q; eper_d = eper_q; ediv_d = ediv_q; evol_d = evol_q;
    tper_d = tper_q; ttim_d = ttim_q; tstep_d = tstep_q;
    tlp_d = tlp_q; tlc_d = tlc_q; tlr_d = tlr_q;
    nper_d = nper_q; ntim_d = ntim_q; nmode_d = nmode_q; lfsr_d = lfsr_q;
    delta = '0; tp = '0; fb = 1'b0; env_loop = 1'b0;

    if (tick_i) begin
      par_d = !par_q;
      if (par_q) begin
        for (int p = 0; p < 2; p++) begin
          if (p < PulseCount) begin
            if (ptim_q[p] == 16'd0) begin
              ptim_d[p] = pper_q[p];
              dstep_d[p] = dstep_q[p] + 3'd1;
            end else begin
              ptim_d[p] = ptim_q[p] - 16'd1;
            end
          end
        end
        if (ntim_q == 12'd0) begin
          ntim_d = nper_q;
          fb = lfsr_q[0] ^ (nmode_q ? lfsr_q[6] : lfsr_q[1]);
          lfsr_d = {fb, lfsr_q[14:1]};
        end else begin
          ntim_d = ntim_q - 12'd1;
        end
      end
      if (ttim_q == 11'd0) begin
        ttim_d = tper_q;
        if (len_q[2] != 8'd0 && tlc_q != 7'd0) tstep_d = tstep_q + 5'd1;
      end else begin
        ttim_d = ttim_q - 11'd1;
      end
    end

    if (ev_i.quarter) begin
      for (int e = 0; e < 3; e++) begin
        if (e == 2 || e < PulseCount) begin
          env_loop = (e == 2) ? halt_q[3] : halt_q[e];
          if (est_q[e]) begin
            evol_d[e] = 4'd15; ediv_d[e] = eper_q[e]; est_d[e] = 1'b0;
          end else if (ediv_q[e] != 4'd0) begin
            ediv_d[e] = ediv_q[e] - 4'd1;
          end else begin
            if (evol_q[e] != 4'd0) evol_d[e] = evol_q[e] - 4'd1;
            else if (env_loop) evol_d[e] = 4'd15;
            ediv_d[e] = eper_q[e];
          end
        end
      end
      if (tlr_q) tlc_d = tlp_q;
      else if (tlc_q != 7'd0) tlc_d = tlc_q - 7'd1;
      if (!halt_q[2]) tlr_d = 1'b0;
    end

    if (ev_i.half) begin
      for (int p = 0; p < 2; p++) begin
        if (p < PulseCount) begin
          delta = pper_q[p] >> swc_q[p][2:0];
          tp = swc_q[p][3] ? (pper_q[p] - delta - ((p == 0) ? 16'd1 : 16'd0))
                           : (pper_q[p] + delta);
          // divider reloads with the sweep period plus one
          if (swr_q[p]) begin
            if (swc_q[p][7] && swdiv_q[p] == 4'd0) pper_d[p] = tp;
            swdiv_d[p] = {1'b0, swc_q[p][6:4]} + 4'd1;
            swr_d[p] = 1'b0;
          end else if (swdiv_q[p] != 4'd0) begin
            swdiv_d[p] = swdiv_q[p] - 4'd1;
          end else begin
            if (swc_q[p][7]) pper_d[p] = tp;
            swdiv_d[p] = {1'b0, swc_q[p][6:4]} + 4'd1;
          end
        end
      end
      for (int c = 0; c < 4; c++)
        if (!halt_q[c] && len_q[c] != 8'd0) len_d[c] = len_q[c] - 8'd1;
    end

    if (wr_i) begin
      if (addr_i < 5'd8) begin
        for (int p = 0; p < 2; p++) begin
          if (p < PulseCount && addr_i[2] == p[0]) begin
            case (addr_i[1:0])
              2'd0: begin
                duty_d[p] = data_i[7:6]; halt_d[p] = data_i[5];
                econ_d[p] = data_i[4]; eper_d[p] = data_i[3:0]; est_d[p] = 1'b1;
              end
              2'd1: begin
                swc_d[p] = data_i; swr_d[p] = 1'b1;
              end
              2'd2: pper_d[p] = {pper_q[p][15:8], data_i};
              default: begin
                len_d[p] = suptn_pkg::len_lookup(data_i[7:3]);
                pper_d[p] = {5'd0, data_i[2:0], pper_q[p][7:0]};
                est_d[p] = 1'b1; dstep_d[p] = 3'd0;
              end
            endcase
          end
        end
      end else begin
        unique case (addr_i)
          suptn_pkg::ADDR_TRI_LIN: begin
            halt_d[2] = data_i[7]; tlp_d = data_i[6:0];
          end
          suptn_pkg::ADDR_TRI_LO: tper_d = {tper_q[10:8], data_i};
          suptn_pkg::ADDR_TRI_HI: begin
            len_d[2] = suptn_pkg::len_lookup(data_i[7:3]);
            tper_d = {data_i[2:0], tper_q[7:0]};
            ttim_d = {data_i[2:0], tper_q[7:0]};
            tlr_d = 1'b1;
          end
          suptn_pkg::ADDR_NOISE_ENV: begin
            halt_d[3] = data_i[5]; econ_d[2] = data_i[4];
            eper_d[2] = data_i[3:0]; est_d[2] = 1'b1;
          end
          suptn_pkg::ADDR_NOISE_PER: begin
            nmode_d = data_i[7]; nper_d = suptn_pkg::noise_lookup(data_i[3:0]);
          end
          suptn_pkg::ADDR_NOISE_LEN: begin
            len_d[3] = suptn_pkg::len_lookup(data_i[7:3]); est_d[2] = 1'b1;
          end
          suptn_pkg::ADDR_STATUS: begin
            en_d = data_i[3:0];
            for (int c = 0; c < 4; c++) if (!data_i[c]) len_d[c] = 8'd0;
          end
          default: ;
        endcase
      end
    end

    // levels from the state after this tick's timer and frame updates
    dmask = '0;
    for (int p = 0; p < 2; p++) begin
      plev[p] = 4'd0;
      dmask = suptn_pkg::duty_lookup(duty_d[p]);
      if (p < PulseCount && en_d[p] && len_d[p] != 8'd0 && dmask[dstep_d[p]] &&
          pper_d[p] >= 16'd8 && pper_d[p] <= 16'h7FF)
        plev[p] = econ_d[p] ? eper_d[p] : evol_d[p];
    end
    pm = {1'b0, plev[0]} + {1'b0, plev[1]};
    pulse_mix_o = pm;
    tlev = 4'd0;
    if (en_d[2] && tper_d >= 11'd3 && len_d[2] != 8'd0)
      tlev = tstep_d[4] ? tstep_d[3:0] : ~tstep_d[3:0];
    nlev = 4'd0;
    if (en_d[3] && len_d[3] != 8'd0 && !lfsr_d[0])
      nlev = econ_d[2] ? eper_d[2] : evol_d[2];
    tri_noise_mix_o = 7'({tlev, 1'b0} + {1'b0, tlev}) + 7'({nlev, 1'b0});
    status_o = {4'd0, len_d[3] != 8'd0, len_d[2] != 8'd0,
                (PulseCount > 1) && len_d[1] != 8'd0, len_d[0] != 8'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= 1'b0; en_q <= '0;
      for (int p = 0; p < 2; p++) begin
        pper_q[p] <= '0; ptim_q[p] <= '0; duty_q[p] <= '0; dstep_q[p] <= '0;
        swc_q[p] <= '0; swr_q[p] <= 1'b0; swdiv_q[p] <= '0;
      end
      for (int c = 0; c < 4; c++) begin
        len_q[c] <= '0; halt_q[c] <= 1'b0;
      end
      for (int e = 0; e < 3; e++) begin
        est_q[e] <= 1'b0; econ_q[e] <= 1'b0; eper_q[e] <= '0;
        ediv_q[e] <= '0; evol_q[e] <= '0;
      end
      tper_q <= '0; ttim_q <= '0; tstep_q <= '0;
      tlp_q <= '0; tlc_q <= '0; tlr_q <= 1'b0;
      nper_q <= '0; ntim_q <= '0; nmode_q <= 1'b0; lfsr_q <= 15'd1;
    end else begin
      par_q <= par_d; en_q <= en_d;
      pper_q <= pper_d; ptim_q <= ptim_d; duty_q <= duty_d; dstep_q <= dstep_d;
      swc_q <= swc_d; swr_q <= swr_d; swdiv_q <= swdiv_d;
      len_q <= len_d; halt_q <= halt_d;
      est_q <= est_d; econ_q <= econ_d; eper_q <= eper_d; ediv_q <= ediv_d; evol_q <= evol_d;
      tper_q <= tper_d; ttim_q <= ttim_d; tstep_q <= tstep_d;
      tlp_q <= tlp_d; tlc_q <= tlc_d; tlr_q <= tlr_d;
      nper_q <= nper_d; ntim_q <= ntim_d; nmode_q <= nmode_d; lfsr_q <= lfsr_d;
    end
  end
endmodule

// File: hdl/suptn_checker.sv
// Port checker for the sound unit, bound to the top level.
module suptn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_opcode,
  input logic               out_valid,
  input logic               out_ready,
  input suptn_pkg::result_t out_payload
);
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid) else $error("result missing");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload)) else $error("result dropped");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("input stalled while empty");
  a_nontick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_opcode != suptn_pkg::OP_TICK |=>
    !out_payload.sample_valid && !out_payload.irq_pulse) else $error("tick field on non-tick");
endmodule

bind sound_unit_pulse_triangle_noise suptn_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready), .in_opcode(in_if.payload.opcode),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_payload(out_if.payload)
);
